### rtl/core/wfe_pkg.sv
// Shared types and constants of the WebSocket frame encoder core.
package wfe_pkg;

   localparam logic MODE_HEADER  = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;

   localparam logic [7:0]  FIN_BIT         = 8'h80;
   localparam logic [6:0]  LEN_CODE_16     = 7'd126;
   localparam logic [6:0]  LEN_CODE_64     = 7'd127;
   localparam logic [63:0] LEN_SHORT_LIMIT = 64'd126;
   localparam logic [63:0] LEN_MID_LIMIT   = 64'd65536;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   localparam int STEP_W = 4;

   typedef enum logic {
      KIND_HEADER,
      KIND_PAYLOAD
   } kind_type;

   typedef enum logic [1:0] {
      LEN_SHORT,
      LEN_MID,
      LEN_LONG
   } len_class_type;

   // One command from the front to the back: a header or one payload byte
   typedef struct packed {
      kind_type      kind;
      logic [7:0]    data;        // first header byte, or masked payload byte
      logic          frame_end;   // payload: last byte; header: empty payload
      logic [63:0]   length;
      logic [31:0]   key;
      logic          masked;
      len_class_type len_class;
   } cmd_type;

endpackage

### rtl/core/wfe_req_if.sv
// Input channel interface: header or payload words.
interface wfe_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [3:0]  opcode;
   logic        final_req;
   logic [63:0] payload_length;
   logic [31:0] mask_key;
   logic [7:0]  data_byte;

   modport source (output valid, mode, opcode, final_req, payload_length, mask_key,
                   data_byte, input ready);
   modport sink (input valid, mode, opcode, final_req, payload_length, mask_key,
                 data_byte, output ready);
endinterface

### rtl/core/wfe_rsp_if.sv
// Output channel interface: encoded frame bytes.
interface wfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source (output valid, out_byte, frame_end, input ready);
   modport sink (input valid, out_byte, frame_end, output ready);
endinterface

### rtl/core/wfe_front.sv
// Front end: accepts words, tracks frame state, masks payload, issues commands.
module wfe_front (
   input  logic            clock,
   input  logic            reset,
   wfe_req_if.sink         req,
   input  logic            masking_on,
   input  logic            queue_full,
   output logic            push,
   output wfe_pkg::cmd_type push_cmd
);
   import wfe_pkg::*;

   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  phase_ff, phase_in;
   logic        masked_ff, masked_in;

   logic        accept;
   logic        is_header;
   logic        has_room;
   logic [7:0]  key_byte;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign is_header = (req.mode == MODE_HEADER);
   assign has_room  = (remaining_ff != 64'd0);

   // Pick the key byte for the current payload index
   always_comb begin
      unique case (phase_ff)
         2'd0: key_byte = key_ff[7:0];
         2'd1: key_byte = key_ff[15:8];
         2'd2: key_byte = key_ff[23:16];
         2'd3: key_byte = key_ff[31:24];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Build the command; drop surplus payload words
   always_comb begin
      push_cmd = '0;
      if (is_header) begin
         push_cmd.kind      = KIND_HEADER;
         push_cmd.data      = (req.final_req ? FIN_BIT : 8'h00) | {4'h0, req.opcode};
         push_cmd.frame_end = (req.payload_length == 64'd0);
         push_cmd.length    = req.payload_length;
         push_cmd.key       = req.mask_key;
         push_cmd.masked    = masking_on;
         if (req.payload_length < LEN_SHORT_LIMIT) begin
            push_cmd.len_class = LEN_SHORT;
         end else if (req.payload_length < LEN_MID_LIMIT) begin
            push_cmd.len_class = LEN_MID;
         end else begin
            push_cmd.len_class = LEN_LONG;
         end
      end else begin
         push_cmd.kind      = KIND_PAYLOAD;
         push_cmd.data      = req.data_byte ^ (masked_ff ? key_byte : 8'h00);
         push_cmd.frame_end = (remaining_ff == 64'd1);
         push_cmd.len_class = LEN_SHORT;
      end
      push = accept && (is_header || has_room);
   end

   // Advance frame state
   always_comb begin
      remaining_in = remaining_ff;
      key_in       = key_ff;
      phase_in     = phase_ff;
      masked_in    = masked_ff;
      if (accept) begin
         if (is_header) begin
            remaining_in = req.payload_length;
            key_in       = req.mask_key;
            phase_in     = 2'd0;
            masked_in    = masking_on;
         end else if (has_room) begin
            remaining_in = remaining_ff - 64'd1;
            phase_in     = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         key_ff       <= '0;
         phase_ff     <= '0;
         masked_ff    <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         phase_ff     <= phase_in;
         masked_ff    <= masked_in;
      end
   end

endmodule

### rtl/core/wfe_queue.sv
// Command queue between front and back ends.
module wfe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wfe_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output wfe_pkg::cmd_type head
);
   import wfe_pkg::*;

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/wfe_back.sv
// Back end: sequences header bytes and payload bytes into the output register.
module wfe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             not_empty,
   input  wfe_pkg::cmd_type head,
   output logic             pop,
   wfe_rsp_if.source        rsp
);
   import wfe_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              end_ff, end_in;

   logic              load;
   logic              go;
   logic [STEP_W-1:0] ext_count;
   logic [STEP_W-1:0] last_step;
   logic [STEP_W-1:0] len_idx;
   logic [STEP_W-1:0] key_idx;
   logic [6:0]        len_code;
   logic [7:0]        len_byte;
   logic [7:0]        key_byte;
   logic [7:0]        hdr_byte;
   logic              step_last;

   assign rsp.valid     = valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.frame_end = end_ff;

   assign load = !valid_ff || rsp.ready;
   assign go   = load && not_empty;

   // Size the header from the length class and masking
   always_comb begin
      unique case (head.len_class)
         LEN_SHORT: begin
            ext_count = STEP_W'(0);
            len_code  = head.length[6:0];
         end
         LEN_MID: begin
            ext_count = STEP_W'(2);
            len_code  = LEN_CODE_16;
         end
         LEN_LONG: begin
            ext_count = STEP_W'(8);
            len_code  = LEN_CODE_64;
         end
         default: begin
            ext_count = STEP_W'(0);
            len_code  = head.length[6:0];
         end
      endcase
      last_step = STEP_W'(1) + ext_count + (head.masked ? STEP_W'(4) : STEP_W'(0));
      step_last = (step_ff == last_step);
      len_idx   = ext_count + STEP_W'(1) - step_ff;
      key_idx   = step_ff - STEP_W'(2) - ext_count;
   end

   // Select extended length byte, big-endian
   always_comb begin
      unique case (len_idx[2:0])
         3'd0: len_byte = head.length[7:0];
         3'd1: len_byte = head.length[15:8];
         3'd2: len_byte = head.length[23:16];
         3'd3: len_byte = head.length[31:24];
         3'd4: len_byte = head.length[39:32];
         3'd5: len_byte = head.length[47:40];
         3'd6: len_byte = head.length[55:48];
         3'd7: len_byte = head.length[63:56];
         default: len_byte = head.length[7:0];
      endcase
   end

   // Select key byte, low byte first
   always_comb begin
      unique case (key_idx[1:0])
         2'd0: key_byte = head.key[7:0];
         2'd1: key_byte = head.key[15:8];
         2'd2: key_byte = head.key[23:16];
         2'd3: key_byte = head.key[31:24];
         default: key_byte = head.key[7:0];
      endcase
   end

   // Pick the header byte for the current step
   always_comb begin
      priority if (step_ff == STEP_W'(0)) begin
         hdr_byte = head.data;
      end else if (step_ff == STEP_W'(1)) begin
         hdr_byte = {head.masked, len_code};
      end else if (step_ff < (STEP_W'(2) + ext_count)) begin
         hdr_byte = len_byte;
      end else begin
         hdr_byte = key_byte;
      end
   end

   // Load the output register and advance the step
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      step_in  = step_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = not_empty;
      end
      if (go) begin
         if (head.kind == KIND_PAYLOAD) begin
            byte_in = head.data;
            end_in  = head.frame_end;
            pop     = 1'b1;
            step_in = '0;
         end else begin
            byte_in = hdr_byte;
            end_in  = head.frame_end && step_last;
            if (step_last) begin
               pop     = 1'b1;
               step_in = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

endmodule

### rtl/core/websocket_frame_encoder_core.sv
// Path: an accepted word is written into the command queue, and the back end then loads
// its first output byte into the output register, from which it is offered on the port.
// Throughput: one payload word per cycle while the queue is not full and the output is
// taken; a header is sent as 2 to 14 bytes (2 + 0, 2 or 8 length bytes + 4 key bytes when
// masked), while the front keeps accepting into a 4-entry command queue.
// Reset (synchronous, active high) empties the queue and output, clears frame state
// and sets masking off.
module websocket_frame_encoder_core (
   input  logic     clock,
   input  logic     reset,
   wfe_req_if.sink  req_chan,
   wfe_rsp_if.source rsp_chan,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data
);
   import wfe_pkg::*;

   logic    masking_on_ff, masking_on_in;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_not_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // Hold the masking control register
   always_comb begin
      masking_on_in = csr_wr_en ? csr_wr_data : masking_on_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masking_on_ff <= 1'b0;
      end else begin
         masking_on_ff <= masking_on_in;
      end
   end

   wfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .masking_on (masking_on_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   wfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   wfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .head      (head_cmd),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

### tb/tb_websocket_frame_encoder_core.sv
// Self-checking testbench for the WebSocket frame encoder core.
module tb_websocket_frame_encoder_core;
   import wfe_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int WORD_TARGET   = 220;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [7:0] MASK_BIT = 8'h80;

   // One input word as the encoder sees it
   typedef struct packed {
      logic        mode;
      logic [3:0]  opcode;
      logic        fin;
      logic [63:0] length;
      logic [31:0] key;
      logic [7:0]  data;
   } enc_word_type;

   // One encoded byte on the wire
   typedef struct packed {
      logic [7:0] wire_byte;
      logic       last;
   } wire_byte_type;

   class frame_scoreboard;
      bit            masking_on;
      bit            frame_masked;
      logic [63:0]   bytes_left;
      logic [31:0]   key_store;
      logic [1:0]    key_phase;
      wire_byte_type expected_bytes[$];
      int            fail_count;

      function new();
         masking_on   = 1'b0;
         frame_masked = 1'b0;
         bytes_left   = '0;
         key_store    = '0;
         key_phase    = '0;
         fail_count   = 0;
      endfunction

      function void set_masking(bit on);
         masking_on = on;
      endfunction

      function void add_byte(logic [7:0] value, logic last);
         wire_byte_type entry;
         entry.wire_byte = value;
         entry.last      = last;
         expected_bytes.insert(expected_bytes.size(), entry);
      endfunction

      // Encode one accepted word; return how many wire bytes it produces
      function int note_word(enc_word_type w);
         int         start_count;
         int         i;
         logic [7:0] second;
         logic [7:0] payload;
         start_count = expected_bytes.size();
         if (w.mode == MODE_HEADER) begin
            // restart the frame, dropping whatever was left of the old one
            frame_masked = masking_on;
            key_store    = w.key;
            key_phase    = '0;
            bytes_left   = w.length;
            add_byte((w.fin ? FIN_BIT : 8'h00) | {4'h0, w.opcode}, 1'b0);
            second = frame_masked ? MASK_BIT : 8'h00;
            if (w.length < LEN_SHORT_LIMIT) begin
               add_byte(second | {1'b0, w.length[6:0]}, 1'b0);
            end else if (w.length < LEN_MID_LIMIT) begin
               add_byte(second | {1'b0, LEN_CODE_16}, 1'b0);
               add_byte(w.length[15:8], 1'b0);
               add_byte(w.length[7:0], 1'b0);
            end else begin
               add_byte(second | {1'b0, LEN_CODE_64}, 1'b0);
               for (i = 7; i >= 0; i--) add_byte(w.length[i*8 +: 8], 1'b0);
            end
            if (frame_masked) begin
               for (i = 0; i < 4; i++) add_byte(w.key[i*8 +: 8], 1'b0);
            end
            // empty payload: the last header byte ends the frame
            if (w.length == 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
         end else if (bytes_left != 0) begin
            payload = w.data;
            if (frame_masked) payload = payload ^ key_store[key_phase*8 +: 8];
            key_phase  = key_phase + 2'd1;
            bytes_left = bytes_left - 64'd1;
            add_byte(payload, bytes_left == 0);
         end
         return expected_bytes.size() - start_count;
      endfunction

      // Compare one accepted output byte with the oldest expectation
      function void check_byte(logic [7:0] value, logic last);
         wire_byte_type entry;
         if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected output byte %02h frame_end %0b", value, last);
         end else begin
            entry = expected_bytes.pop_front();
            if (value !== entry.wire_byte || last !== entry.last) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"output mismatch: expected byte %02h frame_end %0b, ",
                            "got byte %02h frame_end %0b"},
                           entry.wire_byte, entry.last, value, last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   wfe_req_if req_if();
   wfe_rsp_if rsp_if();

   frame_scoreboard frame_sb;
   int idle_pct;
   int words_sent;

   websocket_frame_encoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Draw an idle stretch: mostly none or short, now and then long
   function automatic int draw_gap();
      if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   // Fill every field with noise so ignored fields are exercised
   function automatic enc_word_type noise_word();
      enc_word_type w;
      w.mode   = MODE_PAYLOAD;
      w.opcode = 4'($urandom_range(15));
      w.fin    = 1'($urandom_range(1));
      w.length = {$urandom, $urandom};
      w.key    = $urandom;
      w.data   = 8'($urandom_range(255));
      return w;
   endfunction

   // Present one word, hold it until accepted, then predict its bytes
   task automatic send_word(enc_word_type w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.mode           <= w.mode;
      req_if.opcode         <= w.opcode;
      req_if.final_req      <= w.fin;
      req_if.payload_length <= w.length;
      req_if.mask_key       <= w.key;
      req_if.data_byte      <= w.data;
      do @(posedge clock); while (!req_if.ready);
      void'(frame_sb.note_word(w));
      words_sent++;
   endtask

   task automatic send_header(logic [3:0] opcode, logic fin, logic [63:0] length,
                              logic [31:0] key);
      enc_word_type w;
      w        = noise_word();
      w.mode   = MODE_HEADER;
      w.opcode = opcode;
      w.fin    = fin;
      w.length = length;
      w.key    = key;
      send_word(w);
   endtask

   task automatic send_payload(logic [7:0] data);
      enc_word_type w;
      w      = noise_word();
      w.mode = MODE_PAYLOAD;
      w.data = data;
      send_word(w);
   endtask

   // Drop valid, wait for every expected byte, then let dropped words drain
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (frame_sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_masking(bit on);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_sb.set_masking(on);
   endtask

   // One frame with random content: mostly complete, sometimes cut short or overrun
   task automatic random_frame();
      logic [63:0] length;
      int          kind;
      int          count;
      kind = $urandom_range(99);
      if (kind < 50) begin
         length = 64'($urandom_range(12));
      end else if (kind < 72) begin
         length = 64'($urandom_range(125, 13));
      end else if (kind < 80) begin
         length = 64'($urandom_range(160, 126));
      end else if (kind < 88) begin
         length = 64'($urandom_range(65535, 126));
      end else begin
         length = {$urandom, $urandom};
         if (length < LEN_MID_LIMIT) length[63] = 1'b1;
      end
      send_header(4'($urandom_range(15)), 1'($urandom_range(1)), length, $urandom);
      if (length > 64'd160 || $urandom_range(9) == 0) count = $urandom_range(6);
      else count = int'(length);
      repeat (count) send_payload(8'($urandom_range(255)));
      if (64'(count) == length && $urandom_range(9) == 0)
         repeat ($urandom_range(3, 1)) send_payload(8'($urandom_range(255)));
   endtask

   // Result side: check accepted bytes, stall ready at random
   initial begin : byte_sink
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            frame_sb.check_byte(rsp_if.out_byte, rsp_if.frame_end);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = draw_gap();
         end
      end
   end

   // Abort a hung run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int frame_idx;
      frame_sb = new();
      idle_pct   = 20;
      words_sent = 0;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= 1'b0;
      req_if.valid          <= 1'b0;
      req_if.mode           <= MODE_HEADER;
      req_if.opcode         <= '0;
      req_if.final_req      <= 1'b0;
      req_if.payload_length <= '0;
      req_if.mask_key       <= '0;
      req_if.data_byte      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Unmasked: stray byte before any header, empty frame, size boundaries
      send_payload(8'hA5);
      send_header(4'h0, 1'b1, 64'd0, 32'hFFFF_FFFF);
      send_header(4'hF, 1'b0, 64'd1, 32'h0000_0000);
      send_payload(8'hFF);
      send_payload(8'h00);
      send_header(4'h1, 1'b1, 64'd125, 32'h1234_5678);
      send_payload(8'h3C);
      send_header(4'h2, 1'b0, 64'd126, 32'h0);
      send_payload(8'hC3);
      send_header(4'h8, 1'b1, 64'd65535, 32'h0);
      send_header(4'h9, 1'b1, 64'd65536, 32'h0);
      send_header(4'hA, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hDEAD_BEEF);
      send_payload(8'h5A);

      // Masked: empty frame ends on the last key byte, key wraps past four bytes
      set_masking(1'b1);
      send_header(4'hA, 1'b1, 64'd0, 32'hFFFF_FFFF);
      send_header(4'h1, 1'b1, 64'd5, 32'h1234_5678);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h81);
      send_payload(8'h7E);
      send_payload(8'h55);
      send_payload(8'hAA);
      send_header(4'h2, 1'b0, 64'd127, 32'h0000_0000);
      send_payload(8'h11);
      send_header(4'hF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001);
      send_payload(8'hEE);
      send_header(4'h0, 1'b0, 64'd65536, 32'h0F0F_F0F0);

      // Random phases: alternate masking and idle pressure
      phase = 0;
      while (words_sent < WORD_TARGET) begin
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 25;
            default: idle_pct = 60;
         endcase
         set_masking(phase % 2 == 1);
         for (frame_idx = 0; frame_idx < 6 && words_sent < WORD_TARGET; frame_idx++)
            random_frame();
         phase++;
      end

      wait_idle();
      if (frame_sb.fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
